[rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// shared widths, codes and types for the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VALUE_W   = 32;
  localparam int PRIO_W    = 16;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;

  // kind field codes
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // operation broadcast to every cell of the chain
  typedef struct packed {
    logic               ins;
    logic               rem;
    logic [PRIO_W-1:0]  prio;
    logic [VALUE_W-1:0] value;
  } spq_ctl_t;

endpackage

[rtl/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds an entry, compares, shifts left or right
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                       clk,
  input  spq_pkg::spq_ctl_t          ctl,
  input  logic                       occupied,
  input  logic                       left_after,
  input  logic [spq_pkg::PRIO_W-1:0]  left_prio,
  input  logic [spq_pkg::VALUE_W-1:0] left_value,
  input  logic [spq_pkg::PRIO_W-1:0]  right_prio,
  input  logic [spq_pkg::VALUE_W-1:0] right_value,
  output logic [spq_pkg::PRIO_W-1:0]  prio,
  output logic [spq_pkg::VALUE_W-1:0] value,
  output logic                       after
);

  logic [spq_pkg::PRIO_W-1:0]  prio_next;
  logic [spq_pkg::VALUE_W-1:0] value_next;

  // held entry stays ahead of the new one (equal priority keeps arrival order)
  assign after = occupied && (prio <= ctl.prio);

  always_comb begin
    prio_next  = prio;
    value_next = value;
    if (ctl.ins) begin
      if (!after) begin
        if (left_after) begin
          prio_next  = ctl.prio;
          value_next = ctl.value;
        end else begin
          prio_next  = left_prio;
          value_next = left_value;
        end
      end
    end else if (ctl.rem) begin
      prio_next  = right_prio;
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    prio  <= prio_next;
    value <= value_next;
  end

endmodule

[rtl/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue
// bounded priority queue kept sorted in a chain of compare-and-shift cells
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries kind, value, priority_req.
//   kind insert places value behind every held entry of lower or equal
//   priority number; kind remove returns the head entry and drops it.
//   output channel (out_valid / out_stall) carries one result per input
//   transfer: head_value, status (ok, full, empty) and count after the step.
//   the result is registered, shown in the cycle after the input transfer.
//   one item per cycle unless out_stall holds a result; all cells compare
//   their entries with the broadcast priority and shift one slot at once.
//   an insert on a full queue is dropped with status full; a remove on an
//   empty queue reports status empty with a zero value.
//   the output register is the only buffer: while out_stall holds a waiting
//   result, in_stall is raised; once the result is taken a new item enters
//   in the same cycle.
//   reset clears the entry count and the output valid; entry storage needs
//   no clearing since only occupied cells are ever read.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic [spq_pkg::VALUE_W-1:0]  value,
  input  logic [spq_pkg::PRIO_W-1:0]   priority_req,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [spq_pkg::VALUE_W-1:0]  head_value,
  output logic [spq_pkg::STATUS_W-1:0] status,
  output logic [spq_pkg::COUNT_W-1:0]  count
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  // control state
  logic [CNT_W-1:0] held_count;
  logic [CNT_W-1:0] held_count_next;

  logic accept;
  logic full;
  logic empty;
  logic do_ins;
  logic do_rem;

  spq_pkg::spq_ctl_t ctl;
  spq_pkg::status_t  status_next;

  // chain wiring
  logic [spq_pkg::PRIO_W-1:0]  cell_prio  [DEPTH];
  logic [spq_pkg::VALUE_W-1:0] cell_value [DEPTH];
  logic [DEPTH-1:0]            cell_after;
  logic [DEPTH-1:0]            cell_occ;

  // a new transfer enters unless a finished result is still held back
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign full   = (held_count == CNT_W'(DEPTH));
  assign empty  = (held_count == '0);
  assign do_ins = accept && (kind == spq_pkg::KIND_INSERT) && !full;
  assign do_rem = accept && (kind == spq_pkg::KIND_REMOVE) && !empty;

  assign ctl.ins   = do_ins;
  assign ctl.rem   = do_rem;
  assign ctl.prio  = priority_req;
  assign ctl.value = value;

  always_comb begin
    held_count_next = held_count;
    if (do_ins) begin
      held_count_next = held_count + CNT_W'(1);
    end else if (do_rem) begin
      held_count_next = held_count - CNT_W'(1);
    end
  end

  always_comb begin
    status_next = spq_pkg::ST_OK;
    if (kind == spq_pkg::KIND_INSERT) begin
      if (full) begin
        status_next = spq_pkg::ST_FULL;
      end
    end else if (empty) begin
      status_next = spq_pkg::ST_EMPTY;
    end
  end

  // the cell row; head sits in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                        l_after;
    logic [spq_pkg::PRIO_W-1:0]  l_prio;
    logic [spq_pkg::VALUE_W-1:0] l_value;
    logic [spq_pkg::PRIO_W-1:0]  r_prio;
    logic [spq_pkg::VALUE_W-1:0] r_value;

    assign cell_occ[i] = (CNT_W'(i) < held_count);

    if (i == 0) begin : g_first
      // nothing ahead of the head slot
      assign l_after = 1'b1;
      assign l_prio  = priority_req;
      assign l_value = value;
    end else begin : g_mid
      assign l_after = cell_after[i-1];
      assign l_prio  = cell_prio[i-1];
      assign l_value = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      // tail keeps its contents on remove; slot is free afterwards anyway
      assign r_prio  = cell_prio[i];
      assign r_value = cell_value[i];
    end else begin : g_inner
      assign r_prio  = cell_prio[i+1];
      assign r_value = cell_value[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (cell_occ[i]),
      .left_after  (l_after),
      .left_prio   (l_prio),
      .left_value  (l_value),
      .right_prio  (r_prio),
      .right_value (r_value),
      .prio        (cell_prio[i]),
      .value       (cell_value[i]),
      .after       (cell_after[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      held_count <= held_count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register, loaded on every input transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      head_value <= do_rem ? cell_value[0] : '0;
      status     <= status_next;
      count      <= spq_pkg::COUNT_W'(held_count_next);
    end
  end

endmodule

[rtl/spq_checker.sv]
// ----------------------------------------------------------------------------
// spq_checker
// port-level checks for the sorted priority queue, bound to the top level
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [spq_pkg::VALUE_W-1:0]  head_value,
  input logic [spq_pkg::STATUS_W-1:0] status,
  input logic [spq_pkg::COUNT_W-1:0]  count
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(head_value) && $stable(status)
      && $stable(count))
    else $error("result changed while stalled");

  // every input transfer shows a result next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("input transfer produced no result");

  // underflow reports zero value and empty count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == spq_pkg::ST_EMPTY) |-> (head_value == '0) && (count == '0))
    else $error("empty result with nonzero value or count");

  // dropped insert reports a full queue
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == spq_pkg::ST_FULL)
      |-> (head_value == '0) && (count == spq_pkg::COUNT_W'(DEPTH)))
    else $error("full result with wrong value or count");

  // input is held off only while a result waits
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .head_value (head_value),
  .status     (status),
  .count      (count)
);
